// File: hw/rtl/lfuc_pkg.sv
`default_nettype none

package lfuc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam logic [VAL_W-1:0] GET_MISS_VALUE = '1;
    localparam logic [VAL_W-1:0] PUT_VALUE = '0;

    typedef enum logic [1:0] {
        CELL_NONE    = 2'd0,
        CELL_TOUCH   = 2'd1,
        CELL_REPLACE = 2'd2,
        CELL_FILL    = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     write_value;
        logic     scan_full;
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/lfuc_cell.sv
`default_nettype none

module lfuc_cell #(
    parameter int IDX_W = 4,
    parameter int CNT_W = 16,
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfuc_pkg::cell_cmd_t         cmd,
    input  logic [lfuc_pkg::KEY_W-1:0]  req_key,
    input  logic [lfuc_pkg::VAL_W-1:0]  req_value,
    input  logic [IDX_W-1:0]            tgt_idx,
    input  logic [IDX_W-1:0]            ref_rank,
    input  logic [IDX_W-1:0]            new_rank,
    input  logic                        cand_in_found,
    input  logic [IDX_W-1:0]            cand_in_idx,
    input  logic [IDX_W-1:0]            cand_in_rank,
    input  logic [CNT_W-1:0]            cand_in_cnt,
    output logic                        cand_out_found,
    output logic [IDX_W-1:0]            cand_out_idx,
    output logic [IDX_W-1:0]            cand_out_rank,
    output logic [CNT_W-1:0]            cand_out_cnt,
    output logic                        match,
    output logic [lfuc_pkg::VAL_W-1:0]  value,
    output logic [IDX_W-1:0]            rank
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                       valid_reg, valid_next;
    logic [lfuc_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lfuc_pkg::VAL_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]           rank_reg, rank_next;
    logic                       found_reg, found_next;
    logic [IDX_W-1:0]           cidx_reg, cidx_next;
    logic [IDX_W-1:0]           crank_reg, crank_next;
    logic [CNT_W-1:0]           ccnt_reg, ccnt_next;
    logic                       is_tgt;
    logic                       take_self;

    assign is_tgt = (tgt_idx == MY_IDX);
    assign match  = valid_reg && (key_reg == req_key);
    assign value  = value_reg;
    assign rank   = rank_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        cnt_next   = cnt_reg;
        rank_next  = rank_reg;
        unique case (cmd.op)
            lfuc_pkg::CELL_NONE:
            begin
            end
            lfuc_pkg::CELL_TOUCH:
            begin
                if (is_tgt)
                begin
                    rank_next = new_rank;
                    if (cnt_reg != '1)
                        cnt_next = cnt_reg + CNT_W'(1);
                    if (cmd.write_value)
                        value_next = req_value;
                end
                else if (valid_reg && rank_reg > ref_rank)
                    rank_next = rank_reg - IDX_W'(1);
            end
            lfuc_pkg::CELL_REPLACE:
            begin
                if (is_tgt)
                begin
                    key_next   = req_key;
                    value_next = req_value;
                    cnt_next   = '0;
                    rank_next  = new_rank;
                end
                else if (valid_reg && rank_reg > ref_rank)
                    rank_next = rank_reg - IDX_W'(1);
            end
            lfuc_pkg::CELL_FILL:
            begin
                if (is_tgt)
                begin
                    valid_next = 1'b1;
                    key_next   = req_key;
                    value_next = req_value;
                    cnt_next   = '0;
                    rank_next  = new_rank;
                end
            end
            default:
            begin
            end
        endcase
    end

    // In full mode the stage keeps the valid entry with the lowest count,
    // oldest on a tie; otherwise it keeps the first free entry.
    always_comb
    begin
        if (cmd.scan_full)
            take_self = valid_reg && (!cand_in_found || cnt_reg < cand_in_cnt ||
                        (cnt_reg == cand_in_cnt && rank_reg < cand_in_rank));
        else
            take_self = !valid_reg && !cand_in_found;
        found_next = cand_in_found || take_self;
        cidx_next  = take_self ? MY_IDX : cand_in_idx;
        crank_next = take_self ? rank_reg : cand_in_rank;
        ccnt_next  = take_self ? cnt_reg : cand_in_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        cnt_reg   <= cnt_next;
        rank_reg  <= rank_next;
        cidx_reg  <= cidx_next;
        crank_reg <= crank_next;
        ccnt_reg  <= ccnt_next;
    end

    assign cand_out_found = found_reg;
    assign cand_out_idx   = cidx_reg;
    assign cand_out_rank  = crank_reg;
    assign cand_out_cnt   = ccnt_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lfu_cache_lru_tiebreak_core.sv
// LFU key-value cache with least-recently-used tie-break.
// Requests enter on in_valid/in_ready with func, lookup_key and write_value;
// func selects a get or a put. One result (hit, read_value) leaves on
// out_valid/out_ready for every request, in request order.
// The store is a row of MAX_ENTRIES cells. Each cell holds one entry and
// compares its key in parallel with the others; a candidate register in
// each cell passes the best eviction or free-slot choice to its neighbor.
// A get that hits, or a put of a present key, goes from ST_MATCH via ST_ACT
// back to ST_IDLE; a get that misses, or a put of a new key while the capacity
// is zero, goes from ST_MATCH back to ST_IDLE. The result is registered in
// ST_MATCH, the state after acceptance, once the result register is free. A
// put of a new key then walks the cell chain in ST_SCAN and writes in ST_INSERT.
// The result register frees the input side: a new request is taken while a
// result still waits, and the block holds only in its lookup cycle when the
// result register is still full and out_ready is low.
// cfg_wr_en writes cfg_wr_data into the capacity register at once and should be used when idle.
// Reset empties the cache and sets the capacity to 16.
`default_nettype none

module lfu_cache_lru_tiebreak_core #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [lfuc_pkg::KEY_W-1:0]        lookup_key,
    input  logic signed [lfuc_pkg::VAL_W-1:0] write_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic signed [lfuc_pkg::VAL_W-1:0] read_value,
    input  logic                              cfg_wr_en,
    input  logic [lfuc_pkg::CAP_W-1:0]        cfg_wr_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MATCH  = 5'b00010,
        ST_ACT    = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_INSERT = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [lfuc_pkg::CAP_W-1:0] cap_reg;
    logic [OCC_W-1:0]           occ_reg, occ_next;
    logic [OCC_W-1:0]           cap_eff;
    logic                       func_reg;
    logic [lfuc_pkg::KEY_W-1:0] key_reg;
    logic [lfuc_pkg::VAL_W-1:0] wval_reg;
    logic                       full_reg, full_next;
    logic [IDX_W-1:0]           hidx_reg, hidx_next;
    logic [IDX_W-1:0]           hrank_reg, hrank_next;
    logic [IDX_W-1:0]           scnt_reg, scnt_next;
    logic                       ovalid_reg, ovalid_next;
    logic                       ohit_reg, ohit_next;
    logic [lfuc_pkg::VAL_W-1:0] oval_reg, oval_next;

    lfuc_pkg::cell_cmd_t        cmd;
    logic [IDX_W-1:0]           tgt_idx, ref_rank, new_rank;
    logic [MAX_ENTRIES-1:0]     match;
    logic [lfuc_pkg::VAL_W-1:0] cell_value [MAX_ENTRIES];
    logic [IDX_W-1:0]           cell_rank [MAX_ENTRIES];
    logic                       c_found [MAX_ENTRIES+1];
    logic [IDX_W-1:0]           c_idx [MAX_ENTRIES+1];
    logic [IDX_W-1:0]           c_rank [MAX_ENTRIES+1];
    logic [COUNT_WIDTH-1:0]     c_cnt [MAX_ENTRIES+1];
    logic                       any_hit;
    logic [lfuc_pkg::VAL_W-1:0] hit_value;
    logic [IDX_W-1:0]           hit_idx, hit_rank;
    logic                       out_free;
    logic                       vic_found;
    logic [IDX_W-1:0]           vic_idx, vic_rank;

    assign c_found[0] = 1'b0;
    assign c_idx[0]   = '0;
    assign c_rank[0]  = '0;
    assign c_cnt[0]   = '0;

    generate
        for (genvar g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            lfuc_cell #(
                .IDX_W (IDX_W),
                .CNT_W (COUNT_WIDTH),
                .IDX   (g)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .cmd            (cmd),
                .req_key        (key_reg),
                .req_value      (wval_reg),
                .tgt_idx        (tgt_idx),
                .ref_rank       (ref_rank),
                .new_rank       (new_rank),
                .cand_in_found  (c_found[g]),
                .cand_in_idx    (c_idx[g]),
                .cand_in_rank   (c_rank[g]),
                .cand_in_cnt    (c_cnt[g]),
                .cand_out_found (c_found[g+1]),
                .cand_out_idx   (c_idx[g+1]),
                .cand_out_rank  (c_rank[g+1]),
                .cand_out_cnt   (c_cnt[g+1]),
                .match          (match[g]),
                .value          (cell_value[g]),
                .rank           (cell_rank[g])
            );
        end
    endgenerate

    assign vic_found = c_found[MAX_ENTRIES];
    assign vic_idx   = c_idx[MAX_ENTRIES];
    assign vic_rank  = c_rank[MAX_ENTRIES];

    always_comb
    begin
        if (32'(cap_reg) > MAX_ENTRIES)
            cap_eff = OCC_W'(MAX_ENTRIES);
        else
            cap_eff = OCC_W'(cap_reg);
    end

    always_comb
    begin
        any_hit   = 1'b0;
        hit_value = '0;
        hit_idx   = '0;
        hit_rank  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (match[i])
            begin
                any_hit   = 1'b1;
                hit_value = hit_value | cell_value[i];
                hit_idx   = hit_idx | IDX_W'(i);
                hit_rank  = hit_rank | cell_rank[i];
            end
        end
    end

    assign out_free = !ovalid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        full_next   = full_reg;
        hidx_next   = hidx_reg;
        hrank_next  = hrank_reg;
        scnt_next   = scnt_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ohit_next   = ohit_reg;
        oval_next   = oval_reg;
        cmd.op          = lfuc_pkg::CELL_NONE;
        cmd.write_value = (func_reg == lfuc_pkg::FUNC_PUT);
        cmd.scan_full   = full_reg;
        tgt_idx  = hidx_reg;
        ref_rank = hrank_reg;
        new_rank = IDX_W'(occ_reg - OCC_W'(1));
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MATCH;
            end
            ST_MATCH:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ohit_next   = any_hit;
                    if (func_reg == lfuc_pkg::FUNC_GET)
                        oval_next = any_hit ? hit_value : lfuc_pkg::GET_MISS_VALUE;
                    else
                        oval_next = lfuc_pkg::PUT_VALUE;
                    hidx_next  = hit_idx;
                    hrank_next = hit_rank;
                    full_next  = (occ_reg >= cap_eff);
                    scnt_next  = '0;
                    if (any_hit)
                        state_next = ST_ACT;
                    else if (func_reg == lfuc_pkg::FUNC_PUT && cap_eff != '0)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_ACT:
            begin
                cmd.op     = lfuc_pkg::CELL_TOUCH;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                scnt_next = scnt_reg + IDX_W'(1);
                if (scnt_reg == IDX_W'(MAX_ENTRIES - 1))
                    state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                tgt_idx  = vic_idx;
                ref_rank = vic_rank;
                if (full_reg)
                    cmd.op = lfuc_pkg::CELL_REPLACE;
                else
                begin
                    cmd.op   = lfuc_pkg::CELL_FILL;
                    new_rank = IDX_W'(occ_reg);
                    occ_next = occ_reg + OCC_W'(1);
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cap_reg    <= lfuc_pkg::CAP_RESET;
            occ_reg    <= '0;
            ovalid_reg <= 1'b0;
            full_reg   <= 1'b0;
            scnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            ovalid_reg <= ovalid_next;
            full_reg   <= full_next;
            scnt_reg   <= scnt_next;
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            key_reg  <= lookup_key;
            wval_reg <= write_value;
        end
        hidx_reg  <= hidx_next;
        hrank_reg <= hrank_next;
        ohit_reg  <= ohit_next;
        oval_reg  <= oval_next;
    end

    assign out_valid  = ovalid_reg;
    assign hit        = ohit_reg;
    assign read_value = oval_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= MAX_ENTRIES)
        else $error("occupancy above the number of cells");

    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MATCH |-> $onehot0(match))
        else $error("a key is held by more than one cell");

    a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INSERT |-> vic_found)
        else $error("insert without a chosen cell");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = 16;
    localparam int CNT_MAX = 65535;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic                              func;
    logic [lfuc_pkg::KEY_W-1:0]        lookup_key;
    logic signed [lfuc_pkg::VAL_W-1:0] write_value;
    logic                              out_valid;
    logic                              out_ready;
    logic                              hit;
    logic signed [lfuc_pkg::VAL_W-1:0] read_value;
    logic                              cfg_wr_en;
    logic [lfuc_pkg::CAP_W-1:0]        cfg_wr_data;

    typedef struct {
        logic                       hit;
        logic [lfuc_pkg::VAL_W-1:0] value;
    } lookup_result_t;

    lookup_result_t pending_results[$];

    logic                       slot_used[DEPTH];
    logic [lfuc_pkg::KEY_W-1:0] slot_key[DEPTH];
    logic [lfuc_pkg::VAL_W-1:0] slot_value[DEPTH];
    int unsigned                slot_uses[DEPTH];
    int unsigned                slot_rank[DEPTH];
    int unsigned                fill_level;
    int unsigned                cache_capacity;

    int  error_count;
    int  idle_cycles;
    bit  long_hold;
    bit  finished;
    logic [lfuc_pkg::KEY_W-1:0] key_pool[8];

    lfu_cache_lru_tiebreak_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .lookup_key(lookup_key), .write_value(write_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .read_value(read_value),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what,
                                   input logic [lfuc_pkg::VAL_W-1:0] got,
                                   input logic [lfuc_pkg::VAL_W-1:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    function automatic void unrank(input int s);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_used[i] && i != s && slot_rank[i] > slot_rank[s])
                slot_rank[i]--;
        end
    endfunction

    function automatic void promote(input int s);
        unrank(s);
        slot_rank[s] = fill_level - 1;
        if (slot_uses[s] < CNT_MAX)
            slot_uses[s]++;
    endfunction

    function automatic lookup_result_t predict_lookup(input logic op,
                                                      input logic [lfuc_pkg::KEY_W-1:0] k,
                                                      input logic [lfuc_pkg::VAL_W-1:0] v);
        lookup_result_t r;
        int s;
        int victim;
        int eff_cap;
        s = -1;
        victim = -1;
        eff_cap = (cache_capacity > DEPTH) ? DEPTH : cache_capacity;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (s < 0 && slot_used[i] && slot_key[i] == k)
                s = i;
        end
        r.hit = (s >= 0);
        r.value = lfuc_pkg::PUT_VALUE;
        if (op == lfuc_pkg::FUNC_GET)
        begin
            if (s >= 0)
            begin
                r.value = slot_value[s];
                promote(s);
            end
            else
                r.value = lfuc_pkg::GET_MISS_VALUE;
        end
        else if (s >= 0)
        begin
            slot_value[s] = v;
            promote(s);
        end
        else if (eff_cap != 0)
        begin
            if (fill_level >= eff_cap)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                        (slot_uses[i] == slot_uses[victim] &&
                         slot_rank[i] < slot_rank[victim])))
                        victim = i;
                end
                if (victim >= 0)
                begin
                    unrank(victim);
                    slot_used[victim] = 1'b0;
                    fill_level--;
                end
            end
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!slot_used[i])
                begin
                    slot_used[i] = 1'b1;
                    slot_key[i] = k;
                    slot_value[i] = v;
                    slot_uses[i] = 0;
                    slot_rank[i] = fill_level;
                    fill_level++;
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic random_gap(input int max_long);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, max_long) :
            (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2));
        repeat (n) @(negedge clk);
    endtask

    task automatic send_request(input logic op, input logic [lfuc_pkg::KEY_W-1:0] k,
                                input logic [lfuc_pkg::VAL_W-1:0] v);
        @(negedge clk);
        in_valid <= 1'b1;
        func <= op;
        lookup_key <= k;
        write_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_lookup(op, k, v));
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DEPTH + 6) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [lfuc_pkg::CAP_W-1:0] c);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= c;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cache_capacity = c;
    endtask

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", read_value, lfuc_pkg::VAL_W'(0));
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", lfuc_pkg::VAL_W'(hit),
                                    lfuc_pkg::VAL_W'(want.hit));
                if (read_value !== want.value)
                    report_mismatch("read_value", read_value, want.value);
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (long_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !finished)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        set_capacity(5'd16);
        send_request(lfuc_pkg::FUNC_GET, 32'h0000_0000, 32'h0);
        send_request(lfuc_pkg::FUNC_PUT, 32'h0000_0000, 32'h8000_0000);
        send_request(lfuc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(lfuc_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(lfuc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(lfuc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(lfuc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(lfuc_pkg::FUNC_GET, 32'h5555_AAAA, 32'h0);
    endtask

    task automatic test_eviction_order();
        set_capacity(5'd2);
        send_request(lfuc_pkg::FUNC_PUT, 32'h10, 32'h1);
        send_request(lfuc_pkg::FUNC_PUT, 32'h20, 32'h2);
        send_request(lfuc_pkg::FUNC_GET, 32'h10, 32'h0);
        send_request(lfuc_pkg::FUNC_PUT, 32'h30, 32'h3);
        send_request(lfuc_pkg::FUNC_GET, 32'h20, 32'h0);
        send_request(lfuc_pkg::FUNC_PUT, 32'h40, 32'h4);
        send_request(lfuc_pkg::FUNC_GET, 32'h30, 32'h0);
        send_request(lfuc_pkg::FUNC_GET, 32'h10, 32'h0);
    endtask

    task automatic test_zero_and_oversize_capacity();
        set_capacity(5'd0);
        send_request(lfuc_pkg::FUNC_PUT, 32'h99, 32'h9);
        send_request(lfuc_pkg::FUNC_GET, 32'h99, 32'h0);
        send_request(lfuc_pkg::FUNC_PUT, 32'h10, 32'h11);
        send_request(lfuc_pkg::FUNC_GET, 32'h10, 32'h0);
        set_capacity(5'd31);
        for (int i = 0; i < 18; i++)
            send_request(lfuc_pkg::FUNC_PUT, 32'h100 + i, i);
    endtask

    task automatic test_saturating_count();
        set_capacity(5'd16);
        send_request(lfuc_pkg::FUNC_PUT, 32'hC0DE, 32'h1);
        @(negedge clk);
        for (int i = 0; i < 20; i++)
        begin
            in_valid <= 1'b1;
            func <= lfuc_pkg::FUNC_GET;
            lookup_key <= 32'hC0DE;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            pending_results.push_back(predict_lookup(lfuc_pkg::FUNC_GET, 32'hC0DE, 32'h0));
            @(negedge clk);
        end
        in_valid <= 1'b0;
        for (int i = 0; i < 17; i++)
            send_request(lfuc_pkg::FUNC_PUT, 32'hD000 + i, i);
        send_request(lfuc_pkg::FUNC_GET, 32'hC0DE, 32'h0);
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                long_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_request(i[0], key_pool[i % 8], $urandom);
        join
    endtask

    task automatic test_random_traffic();
        int caps[5];
        logic [lfuc_pkg::KEY_W-1:0] k;
        caps = '{16, 4, 1, 9, 3};
        foreach (caps[c])
        begin
            set_capacity(lfuc_pkg::CAP_W'(caps[c]));
            for (int i = 0; i < 150; i++)
            begin
                if ($urandom_range(0, 9) < 8)
                    k = key_pool[$urandom_range(0, 7)] + $urandom_range(0, 20);
                else
                    k = $urandom;
                send_request(1'($urandom_range(0, 1)), k, $urandom);
                random_gap(40);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = lfuc_pkg::FUNC_GET;
        lookup_key = '0;
        write_value = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        error_count = 0;
        long_hold = 1'b0;
        finished = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_used[i] = 1'b0;
            slot_uses[i] = 0;
            slot_rank[i] = 0;
        end
        fill_level = 0;
        cache_capacity = lfuc_pkg::CAP_RESET;
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_extremes();
        test_eviction_order();
        test_zero_and_oversize_capacity();
        test_saturating_count();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        finished = 1'b1;
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lfuc_pkg.sv
hw/rtl/lfuc_cell.sv
hw/rtl/lfu_cache_lru_tiebreak_core.sv
tb/sv/tb.sv
